// File: hdl/spsr_pkg.sv
// ----------------------------------------------------------------------------
// Swap-pressure swappiness regulator package
// Shared types, constants and helper functions for the regulator.
// ----------------------------------------------------------------------------
package spsr_pkg;

   localparam int SIZE_BITS = 31;

   localparam logic [6:0]  SW_MAX        = 7'd100;
   localparam logic [7:0]  CNT_MAX       = 8'd255;
   localparam logic [7:0]  IDLE_MAX      = 8'd128;
   localparam logic [7:0]  CRIT_IDLE_MAX = 8'd8;
   localparam logic [3:0]  MUL_MAX       = 4'd8;
   localparam logic [3:0]  MUL_RESET     = 4'd1;

   localparam logic [14:0] T_CRIT_MS  = 15'd8000;
   localparam logic [14:0] T_RESTR_MS = 15'd16000;
   localparam logic [14:0] T_NORM_MS  = 15'd32000;

   typedef logic signed [4:0] step_type;

   localparam step_type STEP_M16 = -5'sd16;
   localparam step_type STEP_M8  = -5'sd8;
   localparam step_type STEP_M4  = -5'sd4;
   localparam step_type STEP_M2  = -5'sd2;
   localparam step_type STEP_M1  = -5'sd1;
   localparam step_type STEP_P1  = 5'sd1;
   localparam step_type STEP_P2  = 5'sd2;
   localparam step_type STEP_P4  = 5'sd4;

   typedef enum logic [1:0] {
      INTERVAL_CRIT,
      INTERVAL_RESTR,
      INTERVAL_NORM
   } interval_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] swap_total_kb;
      logic [SIZE_BITS-1:0] swap_free_kb;
      logic [6:0]           active_swappiness;
   } req_payload_type;

   typedef struct packed {
      logic [6:0]  new_swappiness;
      logic        write_done;
      logic        rescheduled;
      logic [17:0] next_interval_ms;
   } rsp_payload_type;

   // A step is dropped when the value already sits at the limit it pushes to
   function automatic logic step_allowed(input logic [6:0] cur, input step_type step);
      logic at_top;
      logic at_bottom;
      at_top    = (cur >= SW_MAX) && !step[4];
      at_bottom = (cur == 7'd0) && (step[4] || (step == 5'sd0));
      return !(at_top || at_bottom);
   endfunction

   function automatic logic [6:0] apply_step(input logic [6:0] cur, input step_type step);
      logic signed [8:0] sum;
      logic [6:0]        res;
      sum = $signed({2'b00, cur}) + $signed({{4{step[4]}}, step});
      if (sum < 9'sd0) begin
         res = 7'd0;
      end else if (sum > $signed({2'b00, SW_MAX})) begin
         res = SW_MAX;
      end else begin
         res = sum[6:0];
      end
      return res;
   endfunction

   function automatic logic [14:0] interval_ms(input interval_type code);
      logic [14:0] ms;
      unique case (code)
         INTERVAL_CRIT:  ms = T_CRIT_MS;
         INTERVAL_RESTR: ms = T_RESTR_MS;
         INTERVAL_NORM:  ms = T_NORM_MS;
         default:        ms = T_CRIT_MS;
      endcase
      return ms;
   endfunction

endpackage

// File: hdl/swap_pressure_swappiness_regulator_unit.sv
// ----------------------------------------------------------------------------
// Swap-pressure swappiness regulator
// An accepted request is held in the input register, then its response in the
// response register. Throughput: one transaction per cycle while not stalled.
// Synchronous active-high reset: multiplier 1, first-sample flag set, counters
// and history cleared, base interval 8000 ms.
// ----------------------------------------------------------------------------
module swap_pressure_swappiness_regulator_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  spsr_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output spsr_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [3:0]                csr_write_data
);
   import spsr_pkg::*;

   // pipeline control
   logic            item_valid_ff, item_valid_in;
   req_payload_type item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            advance;
   logic            fire;

   // regulator state
   logic [3:0]           mul_ff, mul_in;
   logic [SIZE_BITS-1:0] prev_free_ff, prev_free_in;
   logic                 first_ff, first_in;
   logic [7:0]           count_ff, count_in;
   interval_type         base_ff, base_in;

   // datapath
   logic [SIZE_BITS-1:0] total;
   logic [SIZE_BITS-1:0] freek;
   logic [6:0]           cur;
   logic [SIZE_BITS:0]   diff_raw;
   logic                 diff_neg;
   logic                 diff_zero;
   logic [SIZE_BITS-1:0] mag;
   logic                 gt16, gt32, gt64;
   logic                 zone_top, zone_low, zone_restr;
   logic [7:0]           count_inc;
   logic                 pri_try, idle_try;
   step_type             pri_step, idle_step;
   logic                 pri_ok, idle_ok;
   logic [6:0]           val;
   logic                 wrote;
   logic [3:0]           mul_eff;
   logic [18:0]          interval_full;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = item_valid_ff && advance;
   assign req_stall = item_valid_ff && !advance;

   assign item_valid_in = req_valid ? 1'b1 : (advance ? 1'b0 : item_valid_ff);
   assign rsp_valid_in  = fire ? 1'b1 : (advance ? 1'b0 : rsp_valid_ff);

   assign total = item_ff.swap_total_kb;
   assign freek = item_ff.swap_free_kb;
   assign cur   = (item_ff.active_swappiness > SW_MAX) ? SW_MAX
                                                       : item_ff.active_swappiness;

   // diff = previous - current; magnitude used for both fall and rise
   assign diff_raw  = {1'b0, prev_free_ff} - {1'b0, freek};
   assign diff_neg  = diff_raw[SIZE_BITS];
   assign diff_zero = (prev_free_ff == freek);
   assign mag       = diff_neg ? (freek - prev_free_ff) : diff_raw[SIZE_BITS-1:0];

   assign gt16 = mag > (total >> 4);
   assign gt32 = mag > (total >> 5);
   assign gt64 = mag > (total >> 6);

   assign zone_top   = freek >= (total >> 1);
   assign zone_low   = freek <= (total >> 3);
   assign zone_restr = freek <  (total >> 2);

   assign count_inc = (count_ff == CNT_MAX) ? CNT_MAX : count_ff + 8'd1;

   always_comb begin
      pri_try   = 1'b0;
      pri_step  = STEP_M4;
      idle_try  = 1'b0;
      idle_step = STEP_P1;
      base_in   = base_ff;
      if (zone_top) begin
         base_in = INTERVAL_NORM;
      end else if (zone_low) begin
         base_in = INTERVAL_CRIT;
         if (diff_zero) begin
            pri_try  = count_inc > CRIT_IDLE_MAX;
            pri_step = STEP_M4;
         end else if (!diff_neg) begin
            pri_try  = 1'b1;
            pri_step = gt16 ? STEP_M16 : (gt32 ? STEP_M8 : STEP_M4);
         end
      end else if (zone_restr) begin
         base_in   = INTERVAL_RESTR;
         pri_try   = gt64;
         if (!diff_neg) begin
            pri_step = gt16 ? STEP_M4 : (gt32 ? STEP_M2 : STEP_M1);
         end else begin
            pri_step = gt16 ? STEP_P4 : (gt32 ? STEP_P2 : STEP_P1);
         end
         idle_try  = count_inc > IDLE_MAX;
         idle_step = STEP_P1;
      end else begin
         base_in   = INTERVAL_NORM;
         pri_try   = gt32;
         if (!diff_neg) begin
            pri_step = gt16 ? STEP_M2 : STEP_M1;
         end else begin
            pri_step = gt16 ? STEP_P2 : STEP_P1;
         end
         idle_try  = count_inc > IDLE_MAX;
         idle_step = STEP_P2;
      end
   end

   assign pri_ok  = pri_try && step_allowed(cur, pri_step);
   assign idle_ok = idle_try && step_allowed(cur, idle_step);

   always_comb begin
      val   = cur;
      wrote = 1'b0;
      if (zone_top) begin
         // any value short of the maximum jumps straight to it
         if (cur != SW_MAX) begin
            val   = SW_MAX;
            wrote = 1'b1;
         end
      end else if (pri_ok) begin
         val   = apply_step(cur, pri_step);
         wrote = 1'b1;
      end else if (idle_ok) begin
         val   = apply_step(cur, idle_step);
         wrote = 1'b1;
      end
   end

   assign mul_eff = (mul_ff > MUL_MAX) ? MUL_MAX : mul_ff;

   always_comb begin
      prev_free_in  = prev_free_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      interval_full = 19'd0;
      rsp_in        = '{new_swappiness: cur, write_done: 1'b0, rescheduled: 1'b0,
                        next_interval_ms: 18'd0};
      if (total != '0) begin
         prev_free_in       = freek;
         first_in           = 1'b0;
         rsp_in.rescheduled = 1'b1;
         if (first_ff) begin
            interval_full = 19'(interval_ms(base_ff)) * 19'(mul_eff);
         end else begin
            count_in              = (zone_top || wrote) ? 8'd0 : count_inc;
            rsp_in.new_swappiness = val;
            rsp_in.write_done     = wrote;
            interval_full         = 19'(interval_ms(base_in)) * 19'(mul_eff);
         end
         rsp_in.next_interval_ms = interval_full[17:0];
      end
   end

   assign mul_in = csr_write_enable ? csr_write_data : mul_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mul_ff        <= MUL_RESET;
         prev_free_ff  <= '0;
         first_ff      <= 1'b1;
         count_ff      <= 8'd0;
         base_ff       <= INTERVAL_CRIT;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         mul_ff        <= mul_in;
         if (fire) begin
            prev_free_ff <= prev_free_in;
            first_ff     <= first_in;
            count_ff     <= count_in;
            if ((total != '0) && !first_ff) begin
               base_ff <= base_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_payload;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
